FILE: src/mouse_quadrature_iou_assert.svh
// assertion macros shared by the mouse unit
// both expect clk and rst in scope
`ifndef MOUSE_QUADRATURE_IOU_ASSERT_SVH
`define MOUSE_QUADRATURE_IOU_ASSERT_SVH

// consequent checked in the same cycle
`define MQI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MQI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mqi_pkg.sv
`timescale 1ns / 1ps
package mqi_pkg;

  localparam int PHASE_W     = 7;
  localparam int CYC_W       = 16;
  localparam int TOTAL_W     = CYC_W + 1;
  localparam int CNT_W       = 16;
  localparam int RECIP_SHIFT = TOTAL_W + PHASE_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = TOTAL_W + RECIP_W;

  localparam logic [1:0] FUNC_HOST = 2'd0;
  localparam logic [1:0] FUNC_BUS  = 2'd1;
  localparam logic [1:0] FUNC_ADV  = 2'd2;

  localparam logic [7:0] ADDR_CLR_IRQ  = 8'h48;
  localparam logic [7:0] ADDR_MODE_LO  = 8'h58;
  localparam logic [7:0] ADDR_MODE_HI  = 8'h5F;
  localparam logic [7:0] ADDR_X_LATCH  = 8'h15;
  localparam logic [7:0] ADDR_Y_LATCH  = 8'h17;
  localparam logic [7:0] ADDR_ENABLE   = 8'h40;
  localparam logic [7:0] ADDR_X_EDGE   = 8'h42;
  localparam logic [7:0] ADDR_Y_EDGE   = 8'h43;
  localparam logic [7:0] ADDR_BTN      = 8'h63;
  localparam logic [7:0] ADDR_BTN_ALT  = 8'h6B;
  localparam logic [7:0] ADDR_X_DIR    = 8'h66;
  localparam logic [7:0] ADDR_X_DIR_ALT = 8'h6E;
  localparam logic [7:0] ADDR_Y_DIR    = 8'h67;
  localparam logic [7:0] ADDR_Y_DIR_ALT = 8'h6F;

  // mode switch groups, address bits 2:1
  localparam logic [1:0] MODE_GRP_EN     = 2'b00;
  localparam logic [1:0] MODE_GRP_UNUSED = 2'b01;
  localparam logic [1:0] MODE_GRP_X_EDGE = 2'b10;
  localparam logic [1:0] MODE_GRP_Y_EDGE = 2'b11;

  localparam logic signed [CNT_W+1:0] PEND_MAX = 18'sd32767;
  localparam logic signed [CNT_W+1:0] PEND_MIN = -18'sd32768;

  typedef struct packed {
    logic host_load;
    logic step;
    logic clr_latch;
  } mqi_axis_ctl_t;

  typedef struct packed {
    logic nonzero;
    logic fire;
    logic last_pos;
    logic last_neg;
    logic latch;
  } mqi_axis_stat_t;

endpackage

FILE: src/mouse_quadrature_iou.sv
`timescale 1ns / 1ps
// emulated mouse input unit with quadrature outputs
// input channel s_*: one item per handshake, s_tuser carries the function
//   (host position update, bus access, advance cpu cycles)
// output channel m_*: exactly one result item per input item, in order
// host and bus items: from accept through the done state to the output register
// advance items with a nonzero cycle count: the divider captures phase plus
//   elapsed cycles, multiplies by the reciprocal of the scanline length and
//   subtracts back; the scanline count is loaded, then one quadrature step per
//   cycle through both axis units, for at most the elapsed scanlines and
//   stopping once both pending counts are zero; the step state then sees the
//   stepping end and the done state fills the output register
// an advance item with zero cycles takes the short host and bus path
// s_tready is high only while the sequencer is idle
// a finished result sits in the output register; the next item is accepted
//   while it waits, and the sequencer holds the following result until the
//   register is free, so a stalled receiver loses nothing
// reset (rst, synchronous) clears counts, latches, modes, irq and the phase
module mouse_quadrature_iou import mqi_pkg::*; #(
  parameter int SCANLINE_CYCLES = 65
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // host_x, host_y, host_button, reg_addr, is_write, io_disabled, bus_byte,
  // cycle_count
  input  logic [55:0] s_tdata,
  // func
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // claimed, read_data, irq_out
  output logic [15:0] m_tdata
);

  `include "mouse_quadrature_iou_assert.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_STEP, ST_DONE} state_t;

  state_t state;

  // input item fields
  logic [1:0]       func;
  logic [7:0]       host_x;
  logic [7:0]       host_y;
  logic             host_button;
  logic [7:0]       reg_addr;
  logic             is_write;
  logic             io_disabled;
  logic [7:0]       bus_byte;
  logic [CYC_W-1:0] cycle_count;

  assign func        = s_tuser;
  assign host_x      = s_tdata[7:0];
  assign host_y      = s_tdata[15:8];
  assign host_button = s_tdata[16];
  assign reg_addr    = s_tdata[24:17];
  assign is_write    = s_tdata[25];
  assign io_disabled = s_tdata[26];
  assign bus_byte    = s_tdata[34:27];
  assign cycle_count = s_tdata[50:35];

  // unit state
  logic               button_down;
  logic               mouse_enabled;
  logic               x_edge_select;
  logic               y_edge_select;
  logic               irq_line;
  logic [PHASE_W-1:0] scan_phase;
  logic [TOTAL_W-1:0] ticks;
  logic               hold_claim;
  logic [7:0]         hold_rd;

  logic in_acc;
  logic is_host;
  logic is_bus;
  logic is_adv;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign is_host  = (func == FUNC_HOST);
  assign is_bus   = (func == FUNC_BUS);
  assign is_adv   = (func == FUNC_ADV) && (cycle_count != '0);

  // axis units
  mqi_axis_ctl_t  x_ctl, y_ctl;
  mqi_axis_stat_t x_stat, y_stat;
  logic           axis_step;
  logic           dec_clr_all;

  assign axis_step = (state == ST_STEP) && (ticks != '0) &&
                     (x_stat.nonzero || y_stat.nonzero);

  // latch clear straight from the address keeps the decode out of the axis path
  assign x_ctl = '{host_load: in_acc && is_host, step: axis_step,
                   clr_latch: in_acc && is_bus && (reg_addr == ADDR_CLR_IRQ)};
  assign y_ctl = x_ctl;

  mqi_axis u_axis_x (
    .clk      (clk),
    .rst      (rst),
    .ctl      (x_ctl),
    .host_pos (host_x),
    .enable   (mouse_enabled),
    .edge_sel (x_edge_select),
    .stat     (x_stat)
  );

  mqi_axis u_axis_y (
    .clk      (clk),
    .rst      (rst),
    .ctl      (y_ctl),
    .host_pos (host_y),
    .enable   (mouse_enabled),
    .edge_sel (y_edge_select),
    .stat     (y_stat)
  );

  // scanline divider: phase plus elapsed cycles over the scanline length
  logic               div_done;
  logic [TOTAL_W-1:0] div_quo;
  logic [PHASE_W-1:0] div_rem;
  logic [TOTAL_W-1:0] div_total;

  assign div_total = TOTAL_W'(scan_phase) + TOTAL_W'(cycle_count);

  mqi_divider #(
    .DIVISOR (SCANLINE_CYCLES)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (in_acc && is_adv),
    .dividend  (div_total),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // bus access decode
  logic       dec_claim;
  logic [7:0] dec_rd;
  logic       dec_clr_line;
  logic       dec_mode_wr;
  logic       status_bit;

  always_comb begin
    dec_claim    = 1'b0;
    dec_rd       = bus_byte;
    dec_clr_all  = 1'b0;
    dec_clr_line = 1'b0;
    dec_mode_wr  = 1'b0;
    status_bit   = 1'b0;
    if (reg_addr == ADDR_CLR_IRQ) begin
      dec_claim   = 1'b1;
      dec_clr_all = 1'b1;
    end else if (reg_addr >= ADDR_MODE_LO && reg_addr <= ADDR_MODE_HI && !io_disabled) begin
      // the unused pair (address bits 2:1 = 01) is left unclaimed
      dec_mode_wr = (reg_addr[2:1] != MODE_GRP_UNUSED);
      dec_claim   = dec_mode_wr;
    end else if (!is_write) begin
      dec_claim = 1'b1;
      unique case (reg_addr)
        ADDR_X_LATCH: begin
          status_bit   = x_stat.latch;
          dec_clr_line = 1'b1;
        end
        ADDR_Y_LATCH: begin
          status_bit   = y_stat.latch;
          dec_clr_line = 1'b1;
        end
        ADDR_ENABLE:                   status_bit = mouse_enabled;
        ADDR_X_EDGE:                   status_bit = x_edge_select;
        ADDR_Y_EDGE:                   status_bit = y_edge_select;
        ADDR_BTN, ADDR_BTN_ALT:        status_bit = !button_down;
        ADDR_X_DIR, ADDR_X_DIR_ALT:    status_bit = x_stat.last_pos;
        ADDR_Y_DIR, ADDR_Y_DIR_ALT:    status_bit = y_stat.last_neg;
        default:                       dec_claim  = 1'b0;
      endcase
      if (dec_claim) begin
        dec_rd = {status_bit, bus_byte[6:0]};
      end
    end
  end

  // sequencer, mode bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      button_down   <= 1'b0;
      mouse_enabled <= 1'b0;
      x_edge_select <= 1'b0;
      y_edge_select <= 1'b0;
      irq_line      <= 1'b0;
      scan_phase    <= '0;
      ticks         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            hold_claim <= is_bus && dec_claim;
            hold_rd    <= is_bus ? dec_rd : 8'h00;
            state      <= is_adv ? ST_DIV : ST_DONE;
            if (is_host) begin
              button_down <= host_button;
            end
            if (is_bus) begin
              if (dec_clr_all || dec_clr_line) begin
                irq_line <= 1'b0;
              end
              if (dec_mode_wr) begin
                unique case (reg_addr[2:1])
                  MODE_GRP_EN:     mouse_enabled <= reg_addr[0];
                  MODE_GRP_X_EDGE: x_edge_select <= reg_addr[0];
                  MODE_GRP_Y_EDGE: y_edge_select <= reg_addr[0];
                  default: ;
                endcase
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            scan_phase <= div_rem;
            ticks      <= div_quo;
            state      <= ST_STEP;
          end
        end
        ST_STEP: begin
          // leftover scanlines are dropped once both counts reach zero
          if (axis_step) begin
            ticks <= ticks - TOTAL_W'(1);
            if (x_stat.fire || y_stat.fire) begin
              irq_line <= 1'b1;
            end
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, irq_line, hold_rd, hold_claim};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MQI_ASSERT_SAME(a_div_done_in_div, div_done, state == ST_DIV,
    "scanline divide finished outside the divide phase")
  `MQI_ASSERT_NEXT(a_irq_needs_fire,
    !irq_line && !(axis_step && (x_stat.fire || y_stat.fire)), !irq_line,
    "irq line raised without a quadrature edge")
  `MQI_ASSERT_SAME(a_x_latch_enabled, $rose(x_stat.latch), $past(mouse_enabled),
    "x latch set while the mouse was disabled")

endmodule

FILE: src/mqi_divider.sv
`timescale 1ns / 1ps
module mqi_divider import mqi_pkg::*; #(
  parameter int DIVISOR = 65
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TOTAL_W-1:0] dividend,
  output logic               done,
  output logic [TOTAL_W-1:0] quotient,
  output logic [PHASE_W-1:0] remainder
);

  // rounded-up reciprocal, exact for every dividend below 2**TOTAL_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);
  localparam logic [TOTAL_W-1:0] DIV_VAL = TOTAL_W'(DIVISOR);

  logic               mul_stage;
  logic               sub_stage;
  logic [TOTAL_W-1:0] num;
  logic [TOTAL_W-1:0] quo;
  logic [PHASE_W-1:0] rem;
  logic [PROD_W-1:0]  prod;
  logic [TOTAL_W-1:0] rem_full;

  // registered steps in order: capture, reciprocal multiply, subtract back
  assign prod     = PROD_W'(num) * PROD_W'(RECIP);
  assign rem_full = num - quo * DIV_VAL;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_stage <= 1'b0;
      sub_stage <= 1'b0;
      done      <= 1'b0;
    end else begin
      mul_stage <= start;
      sub_stage <= mul_stage;
      done      <= sub_stage;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (mul_stage) begin
      quo <= prod[RECIP_SHIFT +: TOTAL_W];
    end
    if (sub_stage) begin
      rem <= rem_full[PHASE_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: src/mqi_axis.sv
`timescale 1ns / 1ps
module mqi_axis import mqi_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  mqi_axis_ctl_t  ctl,
  input  logic [7:0]     host_pos,
  input  logic           enable,
  input  logic           edge_sel,
  output mqi_axis_stat_t stat
);

  logic [7:0]              last_host;
  logic signed [CNT_W-1:0] pending;
  logic                    phase_bit;
  logic                    last_pos;
  logic                    last_neg;
  logic                    latch;

  logic signed [9:0]       diff;
  logic signed [9:0]       delta;
  logic signed [CNT_W+1:0] sum;
  logic signed [CNT_W-1:0] pending_next;
  logic                    nonzero;
  logic                    fire;

  // wrapped host delta, +128 kept positive
  always_comb begin
    diff = $signed({2'b00, host_pos}) - $signed({2'b00, last_host});
    if (diff > 10'sd128) begin
      delta = diff - 10'sd256;
    end else if (diff < -10'sd128) begin
      delta = diff + 10'sd256;
    end else begin
      delta = diff;
    end
    sum = {{2{pending[CNT_W-1]}}, pending} + {{(CNT_W - 8){delta[9]}}, delta};
    if (sum > PEND_MAX) begin
      pending_next = PEND_MAX[CNT_W-1:0];
    end else if (sum < PEND_MIN) begin
      pending_next = PEND_MIN[CNT_W-1:0];
    end else begin
      pending_next = sum[CNT_W-1:0];
    end
  end

  assign nonzero = (pending != '0);
  assign fire    = ctl.step && nonzero && enable && (phase_bit == edge_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_host <= '0;
      pending   <= '0;
      phase_bit <= 1'b0;
      last_pos  <= 1'b0;
      last_neg  <= 1'b0;
      latch     <= 1'b0;
    end else begin
      if (ctl.host_load) begin
        last_host <= host_pos;
        pending   <= pending_next;
      end
      if (ctl.step && nonzero) begin
        last_pos  <= !pending[CNT_W-1];
        last_neg  <= pending[CNT_W-1];
        pending   <= pending[CNT_W-1] ? pending + CNT_W'(1) : pending - CNT_W'(1);
        phase_bit <= !phase_bit;
      end
      if (fire) begin
        latch <= 1'b1;
      end else if (ctl.clr_latch) begin
        latch <= 1'b0;
      end
    end
  end

  assign stat = '{nonzero: nonzero, fire: fire, last_pos: last_pos,
                  last_neg: last_neg, latch: latch};

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import mqi_pkg::*;

  localparam int SCAN_LEN        = 65;
  localparam int HOLD_LEN        = 300;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int TAIL_CYCLES     = 40;
  localparam int PRINT_CAP       = 50;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int SAT_UPDATES     = 300;

  // codes the package leaves unnamed
  localparam logic [1:0] FUNC_SPARE     = 2'd3;
  localparam logic [7:0] ADDR_MOUSE_OFF = ADDR_MODE_LO;
  localparam logic [7:0] ADDR_MOUSE_ON  = 8'h59;
  localparam logic [7:0] ADDR_MODE_NOP0 = 8'h5A;
  localparam logic [7:0] ADDR_MODE_NOP1 = 8'h5B;
  localparam logic [7:0] ADDR_XEDGE_CLR = 8'h5C;
  localparam logic [7:0] ADDR_XEDGE_SET = 8'h5D;
  localparam logic [7:0] ADDR_YEDGE_CLR = 8'h5E;
  localparam logic [7:0] ADDR_YEDGE_SET = ADDR_MODE_HI;
  localparam logic [7:0] ADDR_UNMAPPED  = 8'h00;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  host_x;
    logic [7:0]  host_y;
    logic        host_button;
    logic [7:0]  reg_addr;
    logic        is_write;
    logic        io_disabled;
    logic [7:0]  bus_byte;
    logic [15:0] cycle_count;
  } mouse_item_t;

  typedef struct {
    logic       claimed;
    logic [7:0] read_data;
    logic       irq_out;
  } mouse_reply_t;

  typedef struct {
    mouse_item_t  item;
    bit           typed;
    mouse_reply_t want;
  } mouse_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // host_x, host_y, host_button, reg_addr, is_write, io_disabled, bus_byte,
  // cycle_count
  logic [55:0] s_tdata;
  // func
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // claimed, read_data, irq_out
  logic [15:0] m_tdata;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mouse_quadrature_iou #(.SCANLINE_CYCLES(SCAN_LEN)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // shadow of the mouse unit state
  logic [7:0] prev_x, prev_y;
  logic       btn_held;
  int         count_x, count_y;
  int         phase_acc;
  logic       en_mouse, edge_x, edge_y;
  logic       quad_x, quad_y, dir_x, dir_y;
  logic       latch_x, latch_y, irq_level;

  mouse_reply_t reply_q[$];
  mouse_row_t   directed_q[$];
  int           mismatch_count = 0;
  int           reply_idx = 0;
  int           idle_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_req = 1'b0;

  // addresses that mean something to the unit, plus the unclaimed mode pair
  logic [7:0] addr_pool [22] = '{
    ADDR_CLR_IRQ, ADDR_MOUSE_OFF, ADDR_MOUSE_ON, ADDR_MODE_NOP0, ADDR_MODE_NOP1,
    ADDR_XEDGE_CLR, ADDR_XEDGE_SET, ADDR_YEDGE_CLR, ADDR_YEDGE_SET, ADDR_X_LATCH,
    ADDR_Y_LATCH, ADDR_ENABLE, ADDR_X_EDGE, ADDR_Y_EDGE, ADDR_BTN, ADDR_BTN_ALT,
    ADDR_X_DIR, ADDR_X_DIR_ALT, ADDR_Y_DIR, ADDR_Y_DIR_ALT, ADDR_X_LATCH, ADDR_Y_LATCH
  };

  // wrapped host delta, +128 stays positive
  function automatic int wrapped_delta(int d);
    if (d > 128) return d - 256;
    if (d < -128) return d + 256;
    return d;
  endfunction

  function automatic int clamp_count(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  task automatic predict_reply(input mouse_item_t it, output mouse_reply_t r);
    int   total;
    int   lines;
    logic fire;
    logic status;
    r.claimed   = 1'b0;
    r.read_data = 8'h00;
    case (it.func)
      FUNC_HOST: begin
        count_x  = clamp_count(count_x + wrapped_delta(int'(it.host_x) - int'(prev_x)));
        count_y  = clamp_count(count_y + wrapped_delta(int'(it.host_y) - int'(prev_y)));
        prev_x   = it.host_x;
        prev_y   = it.host_y;
        btn_held = it.host_button;
      end
      FUNC_BUS: begin
        r.read_data = it.bus_byte;
        if (it.reg_addr == ADDR_CLR_IRQ) begin
          latch_x   = 1'b0;
          latch_y   = 1'b0;
          irq_level = 1'b0;
          r.claimed = 1'b1;
        end else if (it.reg_addr >= ADDR_MODE_LO && it.reg_addr <= ADDR_MODE_HI &&
                     !it.io_disabled) begin
          r.claimed = 1'b1;
          case (it.reg_addr)
            ADDR_MOUSE_OFF: en_mouse = 1'b0;
            ADDR_MOUSE_ON:  en_mouse = 1'b1;
            ADDR_XEDGE_CLR: edge_x = 1'b0;
            ADDR_XEDGE_SET: edge_x = 1'b1;
            ADDR_YEDGE_CLR: edge_y = 1'b0;
            ADDR_YEDGE_SET: edge_y = 1'b1;
            default:        r.claimed = 1'b0;
          endcase
        end else if (!it.is_write) begin
          r.claimed = 1'b1;
          status    = 1'b0;
          case (it.reg_addr)
            ADDR_X_LATCH: begin
              status    = latch_x;
              irq_level = 1'b0;
            end
            ADDR_Y_LATCH: begin
              status    = latch_y;
              irq_level = 1'b0;
            end
            ADDR_ENABLE:                  status = en_mouse;
            ADDR_X_EDGE:                  status = edge_x;
            ADDR_Y_EDGE:                  status = edge_y;
            ADDR_BTN, ADDR_BTN_ALT:       status = !btn_held;
            ADDR_X_DIR, ADDR_X_DIR_ALT:   status = dir_x;
            ADDR_Y_DIR, ADDR_Y_DIR_ALT:   status = dir_y;
            default:                      r.claimed = 1'b0;
          endcase
          if (r.claimed) r.read_data = {status, it.bus_byte[6:0]};
        end
      end
      FUNC_ADV: begin
        if (it.cycle_count != 16'd0) begin
          total     = phase_acc + int'(it.cycle_count);
          lines     = total / SCAN_LEN;
          phase_acc = total % SCAN_LEN;
          // spare scanlines are dropped once both counts reach zero
          while (lines != 0 && (count_x != 0 || count_y != 0)) begin
            lines--;
            fire = 1'b0;
            if (count_x != 0) begin
              dir_x   = (count_x > 0);
              count_x = count_x + ((count_x > 0) ? -1 : 1);
              if (en_mouse && quad_x == edge_x) begin
                latch_x = 1'b1;
                fire    = 1'b1;
              end
              quad_x = !quad_x;
            end
            if (count_y != 0) begin
              // y direction has the opposite polarity
              dir_y   = (count_y < 0);
              count_y = count_y + ((count_y > 0) ? -1 : 1);
              if (en_mouse && quad_y == edge_y) begin
                latch_y = 1'b1;
                fire    = 1'b1;
              end
              quad_y = !quad_y;
            end
            if (fire) irq_level = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.irq_out = irq_level;
  endtask

  function automatic mouse_item_t mk_item(logic [1:0] func);
    mouse_item_t it;
    it.func        = func;
    it.host_x      = 8'h00;
    it.host_y      = 8'h00;
    it.host_button = 1'b0;
    it.reg_addr    = 8'h00;
    it.is_write    = 1'b0;
    it.io_disabled = 1'b0;
    it.bus_byte    = 8'h00;
    it.cycle_count = 16'h0000;
    return it;
  endfunction

  function automatic mouse_item_t mk_bus(logic [7:0] addr, logic wr, logic dis,
                                         logic [7:0] bus);
    mouse_item_t it;
    it             = mk_item(FUNC_BUS);
    it.reg_addr    = addr;
    it.is_write    = wr;
    it.io_disabled = dis;
    it.bus_byte    = bus;
    return it;
  endfunction

  function automatic mouse_item_t mk_host(logic [7:0] x, logic [7:0] y, logic btn);
    mouse_item_t it;
    it             = mk_item(FUNC_HOST);
    it.host_x      = x;
    it.host_y      = y;
    it.host_button = btn;
    return it;
  endfunction

  function automatic mouse_item_t mk_adv(logic [15:0] cyc);
    mouse_item_t it;
    it             = mk_item(FUNC_ADV);
    it.cycle_count = cyc;
    return it;
  endfunction

  // random item with noise in the fields the function ignores
  function automatic mouse_item_t random_item();
    mouse_item_t it;
    int          pick;
    it.host_x      = 8'($urandom);
    it.host_y      = 8'($urandom);
    it.host_button = 1'($urandom);
    it.reg_addr    = 8'($urandom);
    it.is_write    = 1'($urandom);
    it.io_disabled = 1'($urandom);
    it.bus_byte    = 8'($urandom);
    it.cycle_count = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.func = FUNC_HOST;
    end else if (pick < 70) begin
      it.func = FUNC_BUS;
      if ($urandom_range(0, 3) != 0) it.reg_addr = addr_pool[$urandom_range(0, 21)];
      it.io_disabled = ($urandom_range(0, 4) == 0);
    end else if (pick < 97) begin
      it.func = FUNC_ADV;
      // mostly a few scanlines, now and then a long stretch
      pick = $urandom_range(0, 99);
      if (pick < 80) it.cycle_count = 16'($urandom_range(0, 200));
      else if (pick < 95) it.cycle_count = 16'($urandom_range(0, 1000));
    end else begin
      it.func = FUNC_SPARE;
    end
    return it;
  endfunction

  task automatic add_row(input mouse_item_t it, input bit typed, input logic claimed,
                         input logic [7:0] rd, input logic irq);
    mouse_row_t row;
    row.item           = it;
    row.typed          = typed;
    row.want.claimed   = claimed;
    row.want.read_data = rd;
    row.want.irq_out   = irq;
    directed_q.insert(directed_q.size(), row);
  endtask

  // drive one item, then book its predicted reply once it is taken
  task automatic send_item(input mouse_item_t it, input bit typed,
                           input mouse_reply_t want);
    mouse_reply_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, it.cycle_count, it.bus_byte, it.io_disabled, it.is_write,
                 it.reg_addr, it.host_button, it.host_y, it.host_x};
    s_tuser  <= it.func;
    do @(posedge clk); while (!s_tready);
    predict_reply(it, pred);
    reply_q.insert(reply_q.size(), typed ? want : pred);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch on reply %0d, %s: got 0x%0h, want 0x%0h", reply_idx, what, got,
               want);
    mismatch_count++;
  endtask

  // reply checker and no-progress watchdog
  always @(posedge clk) begin
    mouse_reply_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("reply with nothing pending", int'(m_tdata), 0);
        end else begin
          want = reply_q.pop_front();
          if (m_tdata[0] !== want.claimed)
            report_mismatch("claimed", int'(m_tdata[0]), int'(want.claimed));
          if (m_tdata[8:1] !== want.read_data)
            report_mismatch("read_data", int'(m_tdata[8:1]), int'(want.read_data));
          if (m_tdata[9] !== want.irq_out)
            report_mismatch("irq_out", int'(m_tdata[9]), int'(want.irq_out));
        end
        reply_idx <= reply_idx + 1;
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_CYCLES) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    mouse_item_t  it;
    mouse_reply_t none;
    logic [7:0]   run_x, run_y;
    int           send_idle_set [4];
    int           recv_stall_set [4];

    send_idle_set  = '{0, 83, 0, 31};
    recv_stall_set = '{0, 0, 83, 31};
    none.claimed   = 1'b0;
    none.read_data = 8'h00;
    none.irq_out   = 1'b0;

    prev_x = 8'h00; prev_y = 8'h00; btn_held = 1'b0;
    count_x = 0; count_y = 0; phase_acc = 0;
    en_mouse = 1'b0; edge_x = 1'b0; edge_y = 1'b0;
    quad_x = 1'b0; quad_y = 1'b0; dir_x = 1'b0; dir_y = 1'b0;
    latch_x = 1'b0; latch_y = 1'b0; irq_level = 1'b0;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = FUNC_HOST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed rows; typed replies only where they follow from reset or
    // plain decode
    add_row(mk_bus(ADDR_ENABLE, 1'b0, 1'b0, 8'hFF), 1, 1'b1, 8'h7F, 1'b0);
    add_row(mk_bus(ADDR_UNMAPPED, 1'b0, 1'b0, 8'hA5), 1, 1'b0, 8'hA5, 1'b0);
    it = mk_adv(16'hFFFF);
    it.func = FUNC_SPARE;
    it.host_x = 8'hFF; it.host_y = 8'hFF; it.reg_addr = 8'hFF; it.bus_byte = 8'hFF;
    add_row(it, 1, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_MOUSE_ON, 1'b1, 1'b0, 8'h3C), 1, 1'b1, 8'h3C, 1'b0);
    add_row(mk_bus(ADDR_XEDGE_SET, 1'b1, 1'b0, 8'h00), 1, 1'b1, 8'h00, 1'b0);
    // x delta of exactly +128, y delta of +129 wraps to -127
    add_row(mk_host(8'h80, 8'h81, 1'b1), 1, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_BTN, 1'b0, 1'b0, 8'hFF), 1, 1'b1, 8'h7F, 1'b0);
    add_row(mk_adv(16'h0000), 1, 1'b0, 8'h00, 1'b0);
    add_row(mk_adv(16'd64), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_adv(16'd1), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_Y_LATCH, 1'b0, 1'b0, 8'h80), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_X_LATCH, 1'b0, 1'b0, 8'h7F), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_X_DIR, 1'b0, 1'b0, 8'h55), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_Y_DIR_ALT, 1'b0, 1'b0, 8'hAA), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_MODE_NOP0, 1'b1, 1'b0, 8'h11), 0, 1'b0, 8'h00, 1'b0);
    // mode address with the unit's switches masked falls through unclaimed
    add_row(mk_bus(ADDR_MOUSE_OFF, 1'b0, 1'b1, 8'h22), 0, 1'b0, 8'h00, 1'b0);
    // writes to status addresses are ignored
    add_row(mk_bus(ADDR_X_LATCH, 1'b1, 1'b0, 8'h33), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_adv(16'hFFFF), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_CLR_IRQ, 1'b1, 1'b0, 8'hC3), 1, 1'b1, 8'hC3, 1'b0);
    add_row(mk_host(8'h7F, 8'h02, 1'b0), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_host(8'h00, 8'h83, 1'b0), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_YEDGE_SET, 1'b0, 1'b0, 8'h01), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_adv(16'd4000), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_X_EDGE, 1'b0, 1'b0, 8'h00), 0, 1'b0, 8'h00, 1'b0);
    add_row(mk_bus(ADDR_MODE_NOP1, 1'b0, 1'b0, 8'hFE), 0, 1'b0, 8'h00, 1'b0);

    foreach (directed_q[i]) send_item(directed_q[i].item, directed_q[i].typed,
                                      directed_q[i].want);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_idle_set[phase];
      recv_stall_pct = recv_stall_set[phase];
      if (phase == 0) begin
        // steady pushes of one direction drive x to the top and y to the bottom
        // of the count range, with stepping and status reads mixed in
        run_x = prev_x;
        run_y = prev_y;
        for (int i = 0; i < SAT_UPDATES; i++) begin
          run_x = run_x + 8'($urandom_range(120, 127));
          run_y = run_y - 8'($urandom_range(120, 127));
          it = random_item();
          it.func   = FUNC_HOST;
          it.host_x = run_x;
          it.host_y = run_y;
          send_item(it, 1'b0, none);
          if (i % 10 == 9) begin
            it = random_item();
            it.func = FUNC_ADV;
            it.cycle_count = 16'($urandom_range(1, 300));
            send_item(it, 1'b0, none);
            it = random_item();
            it.func = FUNC_BUS;
            it.reg_addr = addr_pool[$urandom_range(0, 21)];
            send_item(it, 1'b0, none);
          end
        end
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // long output hold-off while items keep coming in
        if (phase == 0 && i == 40) hold_req = 1'b1;
        send_item(random_item(), 1'b0, none);
      end
      wait_drained();
    end

    s_tvalid <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && reply_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
